### rtl/core/gbdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbdr_pkg
// Shared types and constants for the breathing duty ramp generator.
// ----------------------------------------------------------------------------
package gbdr_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned INTERVAL_W = 10;
  localparam int unsigned DUTY_W     = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_INTERVAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY      = 1'b1;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 10'd10;
  localparam logic [DUTY_W-1:0]     MAX_DUTY_RESET = 16'd999;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SQUARE,
    ST_SCALE,
    ST_RECIP_LO,
    ST_RECIP_HI,
    ST_EMIT
  } seq_state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SQUARE,
    OP_SCALE,
    OP_RECIP_LO,
    OP_RECIP_HI
  } arith_op_e;

  typedef struct packed {
    arith_op_e op;
  } arith_ctrl_t;

endpackage

### rtl/core/gamma_breathing_duty_ramp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamma_breathing_duty_ramp
// Breathing LED duty generator with a squared (gamma 2) ramp.
// ----------------------------------------------------------------------------
// Steps: a timestamp that does not step returns to idle after its check; one
//   that steps passes through check, square, scale, two reciprocal-multiply
//   halves and emit, in turn on the one shared multiplier; emit waits for a free output.
// A new timestamp is taken only in idle, once the previous one is through.
// Reset: async active low; time base and ramp index cleared, registers to
//   step interval 10 ms and peak duty 999, output empty.
module gamma_breathing_duty_ramp #(
  parameter int unsigned HALF_STEPS = 150
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [gbdr_pkg::TIME_W-1:0]        s_axis_tdata,  // [31:0] now_ms
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [gbdr_pkg::DUTY_W-1:0]        m_axis_tdata,  // [15:0] duty
  input  logic                               cfg_we_i,
  input  logic [gbdr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gbdr_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned PW = $clog2(HALF_STEPS + 1);

  logic [gbdr_pkg::INTERVAL_W-1:0] interval_q;
  logic [gbdr_pkg::DUTY_W-1:0]     max_duty_q;
  logic                            out_valid_q, out_valid_d;
  logic [gbdr_pkg::DUTY_W-1:0]     out_data_q;
  logic                            out_free;
  logic                            out_load;
  logic [PW-1:0]                   phase;
  logic [gbdr_pkg::DUTY_W-1:0]     duty;
  gbdr_pkg::arith_ctrl_t           ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= gbdr_pkg::INTERVAL_RESET;
      max_duty_q <= gbdr_pkg::MAX_DUTY_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gbdr_pkg::CFG_STEP_INTERVAL: interval_q <= cfg_data_i[gbdr_pkg::INTERVAL_W-1:0];
        gbdr_pkg::CFG_MAX_DUTY:      max_duty_q <= cfg_data_i[gbdr_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  gbdr_seq #(
    .HALF_STEPS (HALF_STEPS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .now_i      (s_axis_tdata),
    .interval_i (interval_q),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .ctrl_o     (ctrl),
    .phase_o    (phase)
  );

  gbdr_arith #(
    .HALF_STEPS (HALF_STEPS)
  ) u_arith (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .phase_i    (phase),
    .max_duty_i (max_duty_q),
    .duty_o     (duty)
  );

  // output register; free once the pending transfer completes
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    if (out_load)      out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_data_q <= duty;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_duty_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (duty <= max_duty_q))
    else $error("gamma_breathing_duty_ramp: duty above peak");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("gamma_breathing_duty_ramp: result overwrote pending output");

  a_load_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (m_axis_tvalid && m_axis_tdata == $past(duty)))
    else $error("gamma_breathing_duty_ramp: loaded result not presented");

endmodule

### rtl/core/gbdr_arith.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbdr_arith
// Shared multiplier: phase^2 * max_duty / HALF_STEPS^2, the constant divide
// done as a reciprocal multiply in two half-width passes.
// ----------------------------------------------------------------------------
module gbdr_arith #(
  parameter int unsigned HALF_STEPS = 150
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  gbdr_pkg::arith_ctrl_t           ctrl_i,
  input  logic [$clog2(HALF_STEPS+1)-1:0] phase_i,
  input  logic [gbdr_pkg::DUTY_W-1:0]     max_duty_i,
  output logic [gbdr_pkg::DUTY_W-1:0]     duty_o
);

  localparam int unsigned     PW      = $clog2(HALF_STEPS + 1);
  localparam int unsigned     SQW     = 2 * PW;
  localparam longint unsigned DIVISOR = 64'(HALF_STEPS) * 64'(HALF_STEPS);
  localparam int unsigned     DW      = $clog2(DIVISOR + 64'd1);
  // phase^2 * max_duty stays below DIVISOR * 2^DUTY_W, so below 2^NW
  localparam int unsigned     NW      = DW + gbdr_pkg::DUTY_W;
  // floor(n * RECIP / 2^SH) equals floor(n / DIVISOR) for any n below 2^NW
  localparam int unsigned     SH      = NW + $clog2(DIVISOR);
  localparam longint unsigned RECIP   = ((64'd1 << SH) + DIVISOR - 64'd1) / DIVISOR;
  localparam int unsigned     MW      = $clog2(RECIP + 64'd1);
  localparam int unsigned     AW      = (SQW > (NW + 1) / 2) ? SQW : (NW + 1) / 2;
  localparam int unsigned     PRW     = AW + MW;
  localparam int unsigned     QLSB    = SH - AW;

  logic [AW-1:0]  mul_a;
  logic [MW-1:0]  mul_b;
  logic [PRW-1:0] mul_p;
  logic [NW-1:0]  prod_q, prod_d;
  logic [PRW-1:0] acc_q, acc_d;

  // one multiplier, operands picked by the current step
  always_comb begin
    unique case (ctrl_i.op)
      gbdr_pkg::OP_SCALE: begin
        mul_a = AW'(prod_q[SQW-1:0]);
        mul_b = MW'(max_duty_i);
      end
      gbdr_pkg::OP_RECIP_LO: begin
        mul_a = prod_q[AW-1:0];
        mul_b = MW'(RECIP);
      end
      gbdr_pkg::OP_RECIP_HI: begin
        mul_a = AW'(prod_q[NW-1:AW]);
        mul_b = MW'(RECIP);
      end
      default: begin
        mul_a = AW'(phase_i);
        mul_b = MW'(phase_i);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    prod_d = prod_q;
    acc_d  = acc_q;
    unique case (ctrl_i.op)
      gbdr_pkg::OP_SQUARE: begin
        prod_d = mul_p[NW-1:0];
      end
      gbdr_pkg::OP_SCALE: begin
        prod_d = mul_p[NW-1:0];
      end
      gbdr_pkg::OP_RECIP_LO: begin
        acc_d = mul_p;
      end
      gbdr_pkg::OP_RECIP_HI: begin
        // upper half weighs 2^AW; low half's product is shifted down to match
        acc_d = mul_p + (acc_q >> AW);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign duty_o = acc_q[QLSB +: gbdr_pkg::DUTY_W];

  a_phase_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == gbdr_pkg::OP_SQUARE) |-> (32'(phase_i) <= HALF_STEPS))
    else $error("gbdr_arith: phase above half period");

  // the product fed to the reciprocal is below divisor * 2^DUTY_W
  a_prod_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == gbdr_pkg::OP_RECIP_LO) |->
      (64'(prod_q) < (DIVISOR << gbdr_pkg::DUTY_W)))
    else $error("gbdr_arith: product exceeds quotient range");

  a_quot_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == gbdr_pkg::OP_RECIP_HI) |=>
      ((acc_q >> (QLSB + gbdr_pkg::DUTY_W)) == '0))
    else $error("gbdr_arith: quotient wider than duty");

endmodule

### rtl/core/gbdr_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbdr_seq
// Step sequencer: elapsed-time check, ramp index, phase and arithmetic steps.
// ----------------------------------------------------------------------------
module gbdr_seq #(
  parameter int unsigned HALF_STEPS = 150
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [gbdr_pkg::TIME_W-1:0]       now_i,
  input  logic [gbdr_pkg::INTERVAL_W-1:0]   interval_i,
  input  logic                              out_free_i,
  output logic                              out_load_o,
  output gbdr_pkg::arith_ctrl_t             ctrl_o,
  output logic [$clog2(HALF_STEPS+1)-1:0]   phase_o
);

  localparam int unsigned PW   = $clog2(HALF_STEPS + 1);
  localparam int unsigned IW   = $clog2(2 * HALF_STEPS);
  localparam logic [IW:0] FULL = (IW + 1)'(2 * HALF_STEPS);
  localparam logic [IW:0] HALF = (IW + 1)'(HALF_STEPS);

  gbdr_pkg::seq_state_e state_q, state_d;

  logic [gbdr_pkg::TIME_W-1:0] now_q;
  logic [gbdr_pkg::TIME_W-1:0] last_q, last_d;
  logic [IW-1:0]               idx_q, idx_d;
  logic [PW-1:0]               phase_q, phase_d;
  logic [gbdr_pkg::TIME_W-1:0] elapsed;
  logic                        step;
  logic [IW:0]                 idx_inc;
  logic [IW:0]                 idx_next;
  logic [IW:0]                 fall;
  logic                        accept;

  assign accept  = in_valid_i && in_ready_o;
  assign elapsed = now_q - last_q;
  assign step    = !(elapsed < gbdr_pkg::TIME_W'(interval_i));

  assign idx_inc  = {1'b0, idx_q} + 1'b1;
  assign idx_next = (idx_inc == FULL) ? '0 : idx_inc;
  assign fall     = FULL - idx_next;

  always_comb begin
    state_d    = state_q;
    last_d     = last_q;
    idx_d      = idx_q;
    phase_d    = phase_q;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    ctrl_o.op  = gbdr_pkg::OP_NONE;
    unique case (state_q)
      gbdr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = gbdr_pkg::ST_CHECK;
      end
      gbdr_pkg::ST_CHECK: begin
        if (step) begin
          last_d  = now_q;
          idx_d   = idx_next[IW-1:0];
          phase_d = (idx_next < HALF) ? idx_next[PW-1:0] : fall[PW-1:0];
          state_d = gbdr_pkg::ST_SQUARE;
        end else begin
          state_d = gbdr_pkg::ST_IDLE;
        end
      end
      gbdr_pkg::ST_SQUARE: begin
        ctrl_o.op = gbdr_pkg::OP_SQUARE;
        state_d   = gbdr_pkg::ST_SCALE;
      end
      gbdr_pkg::ST_SCALE: begin
        ctrl_o.op = gbdr_pkg::OP_SCALE;
        state_d   = gbdr_pkg::ST_RECIP_LO;
      end
      gbdr_pkg::ST_RECIP_LO: begin
        ctrl_o.op = gbdr_pkg::OP_RECIP_LO;
        state_d   = gbdr_pkg::ST_RECIP_HI;
      end
      gbdr_pkg::ST_RECIP_HI: begin
        ctrl_o.op = gbdr_pkg::OP_RECIP_HI;
        state_d   = gbdr_pkg::ST_EMIT;
      end
      gbdr_pkg::ST_EMIT: begin
        // wait here while the output register still holds an untaken result
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = gbdr_pkg::ST_IDLE;
        end
      end
      default: state_d = gbdr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gbdr_pkg::ST_IDLE;
      last_q  <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) now_q <= now_i;
    phase_q <= phase_d;
  end

  assign phase_o = phase_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, idx_q} < FULL)
    else $error("gbdr_seq: ramp index out of range");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gbdr_pkg::ST_SQUARE) |-> ((IW + 1)'(phase_q) <= HALF))
    else $error("gbdr_seq: phase above half period");

  a_no_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gbdr_pkg::ST_CHECK && !step) |=> (state_q == gbdr_pkg::ST_IDLE))
    else $error("gbdr_seq: non-stepping item did not return to idle");

endmodule
